[design/rwrs_pkg.sv]
// Package for the read/write request scheduler: op codes, modes, word types.
// No dependencies.
`default_nettype none
package rwrs_pkg;
  localparam int TagW  = 16;
  localparam int FileW = 8;
  localparam int OffW  = 48;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_SERVE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             is_write;
    logic [TagW-1:0]  request_tag;
    logic [FileW-1:0] file_id;
    logic [OffW-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             hazard;
    logic             cancel_found;
    logic             served_valid;
    logic             served_is_write;
    logic [TagW-1:0]  served_tag;
    logic [FileW-1:0] served_file;
    logic [OffW-1:0]  served_offset;
  } rsp_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [FileW-1:0] file;
    logic [OffW-1:0]  off;
  } entry_t;
endpackage
`default_nettype wire

[design/rwrs_if.sv]
// Valid/ready channel interfaces for request, response and config words.
// Depends on rwrs_pkg.
`default_nettype none
interface rwrs_req_if;
  import rwrs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rwrs_rsp_if;
  import rwrs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rwrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/rwrs_front.sv]
// Front end: input word register queue (two entries) between port and back end.
// Depends on rwrs_pkg.
`default_nettype none
module rwrs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  rwrs_pkg::req_t     in_data,
  output logic               q_valid,
  input  wire logic          q_ready,
  output rwrs_pkg::req_t     q_data
);
  import rwrs_pkg::*;
  req_t slot [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, pop;

  assign in_ready = fill != 2'd2;
  assign q_valid  = fill != 2'd0;
  assign q_data   = slot[rp];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wp] <= in_data;
  end
endmodule
`default_nettype wire

[design/rwrs_queue.sv]
// Collapsing queue of request cells: append, parallel match, remove-at with shift.
// Depends on rwrs_pkg.
`default_nettype none
module rwrs_queue #(
  parameter int Depth = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  rwrs_pkg::entry_t      push_entry,
  input  wire logic             remove,
  input  wire logic [$clog2(Depth)-1:0] remove_at,
  input  wire logic [rwrs_pkg::FileW-1:0] cmp_file,
  input  wire logic [rwrs_pkg::OffW-1:0]  cmp_off,
  input  wire logic [rwrs_pkg::TagW-1:0]  cmp_tag,
  output logic                  full,
  output logic                  empty,
  output logic                  hit_fo,
  output logic                  hit_tag,
  output logic [$clog2(Depth)-1:0] hit_tag_at,
  output rwrs_pkg::entry_t      head
);
  import rwrs_pkg::*;
  localparam int CW = $clog2(Depth + 1);
  localparam int IW = $clog2(Depth);
  entry_t qent [Depth];
  logic [CW-1:0] count;
  logic [Depth-1:0] live, m_fo, m_tag;

  assign full  = count == CW'(Depth);
  assign empty = count == '0;
  assign head  = qent[0];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      live[i]  = CW'(i) < count;
      m_fo[i]  = live[i] && qent[i].file == cmp_file && qent[i].off == cmp_off;
      m_tag[i] = live[i] && qent[i].tag == cmp_tag;
    end
    hit_fo = |m_fo;
    hit_tag = |m_tag;
    hit_tag_at = '0;
    for (int i = Depth - 1; i >= 0; i--)
      if (m_tag[i]) hit_tag_at = IW'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count + 1'b1;
    end else if (remove) begin
      count <= count - 1'b1;
    end
    for (int i = 0; i < Depth; i++) begin
      if (push && CW'(i) == count) begin
        qent[i] <= push_entry;
      end else if (remove && !push && IW'(i) >= remove_at && i < Depth - 1) begin
        qent[i] <= qent[(i + 1) % Depth];
      end
    end
  end
endmodule
`default_nettype wire

[design/rwrs_back.sv]
// Back end: two collapsing queues, phase control and the response register.
// Depends on rwrs_pkg and rwrs_queue.
`default_nettype none
module rwrs_back #(
  parameter int Depth = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  priority_mode,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  rwrs_pkg::req_t   q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rwrs_pkg::rsp_t   out_data
);
  import rwrs_pkg::*;
  localparam int IW = $clog2(Depth);
  logic rd_push, wr_push, rd_rm, wr_rm;
  logic [IW-1:0] rd_at, wr_at, rd_tat, wr_tat;
  logic rd_full, wr_full, rd_empty, wr_empty, rd_fo, wr_fo, rd_tg, wr_tg;
  entry_t ent, rd_head, wr_head;
  logic in_write_phase, in_write_phase_next;
  logic go;
  rsp_t rsp;

  assign ent = '{tag: q_data.request_tag, file: q_data.file_id, off: q_data.block_offset};
  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;

  rwrs_queue #(.Depth(Depth)) u_rd (
    .clk, .rst, .push(rd_push), .push_entry(ent), .remove(rd_rm), .remove_at(rd_at),
    .cmp_file(q_data.file_id), .cmp_off(q_data.block_offset), .cmp_tag(q_data.request_tag),
    .full(rd_full), .empty(rd_empty), .hit_fo(rd_fo), .hit_tag(rd_tg),
    .hit_tag_at(rd_tat), .head(rd_head));
  rwrs_queue #(.Depth(Depth)) u_wr (
    .clk, .rst, .push(wr_push), .push_entry(ent), .remove(wr_rm), .remove_at(wr_at),
    .cmp_file(q_data.file_id), .cmp_off(q_data.block_offset), .cmp_tag(q_data.request_tag),
    .full(wr_full), .empty(wr_empty), .hit_fo(wr_fo), .hit_tag(wr_tg),
    .hit_tag_at(wr_tat), .head(wr_head));

  always_comb begin
    logic emp;
    rd_push = 1'b0; wr_push = 1'b0; rd_rm = 1'b0; wr_rm = 1'b0;
    rd_at = rd_tat; wr_at = wr_tat;
    rsp = '0;
    in_write_phase_next = in_write_phase;
    emp = in_write_phase ? wr_empty : rd_empty;
    unique case (op_t'(q_data.op))
      OP_SUBMIT: begin
        rsp.hazard = q_data.is_write ? rd_fo : wr_fo;
        rsp.accepted = q_data.is_write ? !wr_full : !rd_full;
        wr_push = go && q_data.is_write && !wr_full;
        rd_push = go && !q_data.is_write && !rd_full;
      end
      OP_CANCEL: begin
        rsp.cancel_found = q_data.is_write ? wr_tg : rd_tg;
        wr_rm = go && q_data.is_write && wr_tg;
        rd_rm = go && !q_data.is_write && rd_tg;
      end
      OP_SERVE: begin
        if (!(rd_empty && wr_empty)) begin
          if (!emp) begin
            rsp.served_valid = 1'b1;
            rsp.served_is_write = in_write_phase;
            rsp.served_tag = in_write_phase ? wr_head.tag : rd_head.tag;
            rsp.served_file = in_write_phase ? wr_head.file : rd_head.file;
            rsp.served_offset = in_write_phase ? wr_head.off : rd_head.off;
            wr_rm = go && in_write_phase;
            rd_rm = go && !in_write_phase;
            wr_at = '0;
            rd_at = '0;
          end
          if (in_write_phase) begin
            if (mode_t'(priority_mode) != MODE_WRITE || emp) in_write_phase_next = 1'b0;
          end else begin
            if (mode_t'(priority_mode) != MODE_READ || emp) in_write_phase_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_write_phase <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (go) in_write_phase <= in_write_phase_next;
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (go) out_data <= rsp;
  end
endmodule
`default_nettype wire

[design/read_write_request_scheduler.sv]
// Top level of the read/write request scheduler.
// Depends on rwrs_pkg, rwrs_if, rwrs_front, rwrs_back.
// In the back end, the collapsing queues match all cells in parallel and shift in
// one step for each word (submit, cancel or serve). A two-word front queue
// decouples the input port; the response is registered, so one word per cycle is
// sustained while the response port is not stalled by out_ready.
`default_nettype none
module read_write_request_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  rwrs_req_if.sink   req,
  rwrs_rsp_if.source rsp,
  rwrs_cfg_if.sink   cfg
);
  import rwrs_pkg::*;
  logic [1:0] priority_mode;
  logic q_valid, q_ready;
  req_t q_data;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) priority_mode <= MODE_NONE;
    else if (cfg.valid) priority_mode <= cfg.data;
  end

  rwrs_front u_front (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .q_valid, .q_ready, .q_data);

  rwrs_back #(.Depth(QUEUE_DEPTH)) u_back (
    .clk, .rst, .priority_mode, .q_valid, .q_ready, .q_data,
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule
`default_nettype wire

[verif/read_write_request_scheduler_tb.sv]
// Testbench for read_write_request_scheduler: directed and random words checked
// against a queue-level scheduler model. Depends on rwrs_pkg, rwrs_if and read_write_request_scheduler.
`timescale 1ns / 100ps
module read_write_request_scheduler_tb;
  import rwrs_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rwrs_req_if req_ch ();
  rwrs_rsp_if rsp_ch ();
  rwrs_cfg_if cfg_ch ();

  read_write_request_scheduler #(.QUEUE_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  req_t   pending_words[$];
  rsp_t   expected_rsps[$];
  entry_t read_q[$];
  entry_t write_q[$];
  logic [1:0] sched_mode = MODE_NONE;
  logic       phase_wr = 1'b1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  bit req_fired = 1'b0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  function automatic rsp_t schedule_word(req_t w);
    rsp_t r;
    bit found;
    bit empty;
    logic [1:0] m;
    entry_t ne;
    int idx;
    r = '0;
    found = 1'b0;
    idx = -1;
    ne = '{w.request_tag, w.file_id, w.block_offset};
    case (op_t'(w.op))
      OP_SUBMIT: begin
        if (w.is_write) begin
          foreach (read_q[i])
            if (read_q[i].file == w.file_id && read_q[i].off == w.block_offset) found = 1'b1;
          if (write_q.size() < Depth) begin
            write_q = {write_q, ne};
            r.accepted = 1'b1;
          end
        end else begin
          foreach (write_q[i])
            if (write_q[i].file == w.file_id && write_q[i].off == w.block_offset) found = 1'b1;
          if (read_q.size() < Depth) begin
            read_q = {read_q, ne};
            r.accepted = 1'b1;
          end
        end
        r.hazard = found;
      end
      OP_CANCEL: begin
        if (w.is_write) begin
          foreach (write_q[i])
            if (idx < 0 && write_q[i].tag == w.request_tag) idx = i;
          if (idx >= 0) write_q.delete(idx);
        end else begin
          foreach (read_q[i])
            if (idx < 0 && read_q[i].tag == w.request_tag) idx = i;
          if (idx >= 0) read_q.delete(idx);
        end
        r.cancel_found = (idx >= 0);
      end
      OP_SERVE: begin
        if (read_q.size() + write_q.size() != 0) begin
          m = (sched_mode == MODE_ALT) ? MODE_NONE : sched_mode;
          empty = phase_wr ? (write_q.size() == 0) : (read_q.size() == 0);
          if (!empty) begin
            entry_t e;
            if (phase_wr) begin
              e = write_q[0];
              write_q.delete(0);
            end else begin
              e = read_q[0];
              read_q.delete(0);
            end
            r.served_valid = 1'b1;
            r.served_is_write = phase_wr;
            r.served_tag = e.tag;
            r.served_file = e.file;
            r.served_offset = e.off;
          end
          if (phase_wr) begin
            if (m != MODE_WRITE || empty) phase_wr = 1'b0;
          end else begin
            if (m != MODE_READ || empty) phase_wr = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_rsp;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    req_fired <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", rsp_ch.data);
        end else begin
          exp_rsp = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp_ch.data !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", exp_rsp, rsp_ch.data);
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_rsps = {expected_rsps, schedule_word(req_ch.data)};
      if (cfg_ch.valid && cfg_ch.ready) sched_mode = cfg_ch.data;
    end
  end

  // driver: hold a word until accepted, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!req_ch.valid || req_fired) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.data <= pending_words[0];
          pending_words.delete(0);
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic req_t mk(op_t op, bit wr, logic [15:0] tag, logic [7:0] f,
                              logic [47:0] off);
    req_t w;
    w.op = op;
    w.is_write = wr;
    w.request_tag = tag;
    w.file_id = f;
    w.block_offset = off;
    return w;
  endfunction

  function automatic void add_word(req_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic req_t random_word(int submit_pct);
    req_t w;
    int r;
    logic [47:0] offs [4];
    offs = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1234, 48'h8000_0000_0001};
    r = $urandom_range(0, 99);
    if (r < submit_pct) w.op = OP_SUBMIT;
    else if (r < submit_pct + 15) w.op = OP_CANCEL;
    else if (r < 96) w.op = OP_SERVE;
    else w.op = OP_NOP;
    w.is_write = 1'($urandom_range(0, 1));
    w.request_tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    w.file_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) w.block_offset = {16'($urandom), 32'($urandom)};
    else w.block_offset = offs[$urandom_range(0, 3)];
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    cfg_ch.data <= m;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int idle_tab [4][2];
    logic [1:0] modes [8];
    idle_tab = '{'{0, 0}, '{50, 0}, '{0, 50}, '{11, 11}};
    modes = '{MODE_NONE, MODE_READ, MODE_WRITE, MODE_ALT,
              MODE_WRITE, MODE_READ, MODE_NONE, MODE_ALT};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: serve on empty, hazards, extremes, full queue, cancels, nop
    add_word(mk(OP_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));
    add_word(mk(OP_SUBMIT, 1'b0, 16'h0000, 8'hFF, 48'hFFFF_FFFF_FFFF));
    add_word(mk(OP_SUBMIT, 1'b1, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
    add_word(mk(OP_SUBMIT, 1'b1, 16'h0005, 8'h00, 48'h0));
    add_word(mk(OP_SUBMIT, 1'b1, 16'h0005, 8'h01, 48'h1));
    add_word(mk(OP_CANCEL, 1'b1, 16'h0005, 8'h0, 48'h0));
    add_word(mk(OP_CANCEL, 1'b0, 16'h7777, 8'h0, 48'h0));
    add_word(mk(OP_NOP, 1'b1, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
    for (int i = 0; i < 16; i++)
      add_word(mk(OP_SUBMIT, 1'b0, 16'(i + 1), 8'(i), 48'(i)));
    add_word(mk(OP_SUBMIT, 1'b1, 16'h00AA, 8'h00, 48'h0));
    for (int i = 0; i < 6; i++) add_word(mk(OP_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(modes[ph]);
      send_idle_pct = idle_tab[ph % 4][0];
      recv_stall_pct = idle_tab[ph % 4][1];
      for (int i = 0; i < 150; i++)
        add_word(random_word((ph % 2) ? 55 : 35));
      drain();
    end

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
